FILE: hw/rtl/crank_pkg.sv
// Package for the combination unrank core: request and result types and
// the binomial row builder used by the walk stages. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package crank_pkg;

    // Entries per binomial row, one for each k from 0 to 32
    localparam int unsigned ROW_ENTRIES = 33;

    // One incoming request
    typedef struct packed {
        logic [31:0] rank_index;
        logic [5:0]  set_size;
        logic [4:0]  subset_size;
    } in_item_t;

    // One emitted subset element
    typedef struct packed {
        logic [3:0] position;
        logic [4:0] element;
        logic       in_range;
        logic       last;
    } out_item_t;

    // C(n,0..32) for one n; every entry fits 32 bits for n <= 31
    typedef logic [ROW_ENTRIES-1:0][31:0] binom_row_t;

    // Pascal triangle row by additions, evaluated at elaboration only
    function automatic binom_row_t binom_row(input int n);
        binom_row_t row;
        row    = '0;
        row[0] = 32'd1;
        for (int i = 1; i <= n; i++) begin
            for (int j = i; j >= 1; j--) begin
                if (j < ROW_ENTRIES) begin
                    row[j] = row[j] + row[j-1];
                end
            end
        end
        return row;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/combination_unrank_core.sv
// Top level of the combination unrank core: input register, walk pipeline
// and result emitter. Depends on crank_pkg and crank_stage.
`timescale 1ns / 1ps
`default_nettype none

// Maps a rank to the k-element subset of {0..n-1} with that colex rank and
// emits the k elements in ascending order, one result per cycle while m_ready
// is high, the last one marked. A request passes an input register, MAX_SET
// walk stages, one per candidate element, and the emitter register. A request
// can enter every cycle while the pipeline is not stalled; the emitter takes
// a new request only once the last result of the one before is taken.
// With k = subset_size, requests with k = 0 or k > MAX_SUBSET are taken and
// give no results. A rank not below C(n,k), or n > MAX_SET, gives k results
// with element 0 and in_range 0.
module combination_unrank_core #(
    parameter int MAX_SET    = 32,
    parameter int MAX_SUBSET = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire crank_pkg::in_item_t   s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output crank_pkg::out_item_t       m_data
);

    localparam int KW = $clog2(MAX_SUBSET + 1);
    localparam int IW = (MAX_SUBSET > 1) ? $clog2(MAX_SUBSET) : 1;

    // Pipeline taps: index 0 is the input register, MAX_SET the last stage
    logic                        pv    [0:MAX_SET];
    logic [31:0]                 prank [0:MAX_SET];
    logic [5:0]                  pset  [0:MAX_SET];
    logic [KW-1:0]               pleft [0:MAX_SET];
    logic [KW-1:0]               pk    [0:MAX_SET];
    logic                        pbad  [0:MAX_SET];
    logic [MAX_SUBSET-1:0][4:0]  pstore[0:MAX_SET];

    logic                        en;
    logic                        emit_free;
    logic                        last_w;
    logic                        walk_ok;

    // Input register
    logic                        in_valid_reg;
    logic [31:0]                 in_rank_reg;
    logic [5:0]                  in_set_reg;
    logic [KW-1:0]               in_k_reg;
    logic                        in_bad_reg;
    logic                        keep;

    // Emitter
    logic                        busy_reg;
    logic [MAX_SUBSET-1:0][4:0]  em_store_reg;
    logic [KW-1:0]               em_k_reg;
    logic                        em_ok_reg;
    logic [IW-1:0]               pos_reg;

    // Requests with an empty or oversized subset produce nothing
    assign keep = (s_data.subset_size != 5'd0) &&
                  ({1'b0, s_data.subset_size} <= 6'(MAX_SUBSET));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (en) begin
            in_valid_reg <= s_valid && keep;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in_rank_reg <= s_data.rank_index;
            in_set_reg  <= s_data.set_size;
            in_k_reg    <= KW'(s_data.subset_size);
            in_bad_reg  <= (s_data.set_size > 6'(MAX_SET));
        end
    end

    assign pv[0]     = in_valid_reg;
    assign prank[0]  = in_rank_reg;
    assign pset[0]   = in_set_reg;
    assign pleft[0]  = in_k_reg;
    assign pk[0]     = in_k_reg;
    assign pbad[0]   = in_bad_reg;
    assign pstore[0] = '0;

    // Walk stages, candidate MAX_SET down to 1
    for (genvar j = 0; j < MAX_SET; j++) begin : g_walk
        crank_stage #(
            .CAND       (MAX_SET - j),
            .MAX_SUBSET (MAX_SUBSET)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (pv[j]),
            .in_rank   (prank[j]),
            .in_set    (pset[j]),
            .in_left   (pleft[j]),
            .in_k      (pk[j]),
            .in_bad    (pbad[j]),
            .in_store  (pstore[j]),
            .out_valid (pv[j+1]),
            .out_rank  (prank[j+1]),
            .out_set   (pset[j+1]),
            .out_left  (pleft[j+1]),
            .out_k     (pk[j+1]),
            .out_bad   (pbad[j+1]),
            .out_store (pstore[j+1])
        );
    end

    // In range exactly when n <= MAX_SET, the walk placed every element and used the rank up
    assign walk_ok = !pbad[MAX_SET] && (pleft[MAX_SET] == '0) && (prank[MAX_SET] == 32'd0);

    // Pipeline moves when its tail is empty or the emitter takes it
    assign last_w    = ((KW'(pos_reg) + KW'(1)) == em_k_reg);
    assign emit_free = !busy_reg || (m_ready && last_w);
    assign en        = !pv[MAX_SET] || emit_free;
    assign s_ready   = en;

    // Emitter control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            pos_reg  <= '0;
        end else if (emit_free) begin
            busy_reg <= pv[MAX_SET];
            pos_reg  <= '0;
        end else if (m_ready) begin
            pos_reg  <= pos_reg + IW'(1);
        end
    end

    // Emitter payload
    always_ff @(posedge aclk) begin
        if (emit_free && pv[MAX_SET]) begin
            em_store_reg <= pstore[MAX_SET];
            em_k_reg     <= pk[MAX_SET];
            em_ok_reg    <= walk_ok;
        end
    end

    // Result request
    always_comb begin
        m_valid         = busy_reg;
        m_data.position = 4'(pos_reg);
        m_data.element  = em_ok_reg ? em_store_reg[pos_reg] : 5'd0;
        m_data.in_range = em_ok_reg;
        m_data.last     = last_w;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/crank_stage.sv
// One registered step of the unranking walk for a fixed candidate element.
// Depends on crank_pkg for the binomial row.
`timescale 1ns / 1ps
`default_nettype none

module crank_stage #(
    parameter int CAND       = 32,
    parameter int MAX_SUBSET = 16
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             en,
    input  wire logic                             in_valid,
    input  wire logic [31:0]                      in_rank,
    input  wire logic [5:0]                       in_set,
    input  wire logic [$clog2(MAX_SUBSET+1)-1:0]  in_left,
    input  wire logic [$clog2(MAX_SUBSET+1)-1:0]  in_k,
    input  wire logic                             in_bad,
    input  wire logic [MAX_SUBSET-1:0][4:0]       in_store,
    output logic                                  out_valid,
    output logic [31:0]                           out_rank,
    output logic [5:0]                            out_set,
    output logic [$clog2(MAX_SUBSET+1)-1:0]       out_left,
    output logic [$clog2(MAX_SUBSET+1)-1:0]       out_k,
    output logic                                  out_bad,
    output logic [MAX_SUBSET-1:0][4:0]            out_store
);

    localparam int KW = $clog2(MAX_SUBSET + 1);
    localparam crank_pkg::binom_row_t ROW = crank_pkg::binom_row(CAND - 1);

    logic                         valid_reg;
    logic [31:0]                  rank_reg, rank_next;
    logic [5:0]                   set_reg;
    logic [KW-1:0]                left_reg, left_next;
    logic [KW-1:0]                k_reg;
    logic                         bad_reg;
    logic [MAX_SUBSET-1:0][4:0]   store_reg, store_next;

    logic        active;
    logic [31:0] binom_v;
    logic        hit;

    // Compare against C(CAND-1, left), take the candidate on a hit
    always_comb begin
        active     = (in_set >= 6'(CAND)) && (in_left != '0);
        binom_v    = ROW[6'(in_left)];
        hit        = active && (in_rank >= binom_v);
        rank_next  = hit ? (in_rank - binom_v) : in_rank;
        left_next  = hit ? (in_left - KW'(1)) : in_left;
        store_next = in_store;
        for (int i = 0; i < MAX_SUBSET; i++) begin
            if (hit && ((in_left - KW'(1)) == KW'(i))) begin
                store_next[i] = 5'(CAND - 1);
            end
        end
    end

    // Valid bit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (en) begin
            rank_reg  <= rank_next;
            set_reg   <= in_set;
            left_reg  <= left_next;
            k_reg     <= in_k;
            bad_reg   <= in_bad;
            store_reg <= store_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_rank  = rank_reg;
    assign out_set   = set_reg;
    assign out_left  = left_reg;
    assign out_k     = k_reg;
    assign out_bad   = bad_reg;
    assign out_store = store_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/crank_sva.sv
// Port-level checks for combination_unrank_core, attached by bind.
// Depends on crank_pkg for the request and result types.
`timescale 1ns / 1ps
`default_nettype none

module crank_sva (
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_valid,
    input wire logic                  s_ready,
    input wire crank_pkg::in_item_t   s_data,
    input wire logic                  m_valid,
    input wire logic                  m_ready,
    input wire crank_pkg::out_item_t  m_data
);

    // Reset empties the result side
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // A stalled result request holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled result request changed");

    // Slots of one subset follow back to back, in order
    a_position: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_data.last) |=>
            (m_valid && (m_data.position == $past(m_data.position) + 4'd1)
             && (m_data.in_range == $past(m_data.in_range)))
        )
        else $error("subset slot sequence broken");

    // Elements of a valid subset strictly ascend
    a_ascend: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_data.last && m_data.in_range) |=>
            (m_data.element > $past(m_data.element)))
        else $error("subset elements not ascending");

    // Out-of-range subsets carry zero elements
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.in_range) |-> (m_data.element == 5'd0))
        else $error("out-of-range element not zero");

endmodule

bind combination_unrank_core crank_sva u_crank_sva (.*);

`default_nettype wire
